@@ design/pdu_pkg.sv @@
package pdu_pkg;

  // character codes
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharDot = 8'h2E;

  // operation codes
  localparam logic OpData    = 1'b0;
  localparam logic OpRestart = 1'b1;

  // default depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // one command from the classifier: optional line break, then optional byte
  typedef struct packed {
    logic       has_break;
    logic       has_byte;
    logic       msg_end;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ design/pop_dot_unstuffing_filter_core.sv @@
// dot unstuffing filter for multi-line mail responses
//
// input channel: in_valid_i / in_stall_o carry one transaction per cycle
// unless stalled; operation_i selects a data byte or a restart, in_byte_i
// is the raw byte. output channel: out_valid_o / out_stall_i carry one
// emitted byte per transaction, with last_of_run_o on the final byte of an
// input and message_end_o on the line feed that closes the message.
// an input gives zero to three output bytes; a held line break goes out
// as CR LF ahead of the byte that follows it.
// the first output byte of an input is read from the command queue, so it is
// registered. throughput: one input per cycle while each gives at most one
// byte and the receiver does not stall; an input giving more bytes holds the
// output side until its last byte goes, and the input side keeps going until
// the command queue (Depth entries) is full. when the receiver stalls, the
// current byte holds and the queue fills, then in_stall_o rises.
// reset clears all stuffing flags, the ended mark and the queue.
module pop_dot_unstuffing_filter_core #(
  parameter int unsigned Depth = pdu_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       message_end_o
);
  import pdu_pkg::*;

  logic q_ready, push, pop, head_valid;
  cmd_t cmd, head;

  pdu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_byte_i   (in_byte_i),
    .q_ready_i   (q_ready),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  pdu_queue #(.Depth(Depth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pdu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .message_end_o (message_end_o)
  );

endmodule

@@ design/pdu_front.sv @@
module pdu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           operation_i,
  input  logic [7:0]     in_byte_i,
  input  logic           q_ready_i,
  output logic           in_stall_o,
  output logic           push_o,
  output pdu_pkg::cmd_t  cmd_o
);
  import pdu_pkg::*;

  logic cr_q, cr_d;
  logic lf_q, lf_d;
  logic dot_q, dot_d;
  logic crdot_q, crdot_d;
  logic ended_q, ended_d;
  logic accept;
  cmd_t cmd;

  assign in_stall_o = !q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  // classify the byte against the stuffing flags
  always_comb begin
    cr_d    = cr_q;
    lf_d    = lf_q;
    dot_d   = dot_q;
    crdot_d = crdot_q;
    ended_d = ended_q;
    cmd     = '0;
    if (operation_i == OpRestart) begin
      cr_d    = 1'b0;
      lf_d    = 1'b0;
      dot_d   = 1'b0;
      crdot_d = 1'b0;
      ended_d = 1'b0;
    end else if (!ended_q) begin
      priority if (in_byte_i == CharCr) begin
        cr_d = 1'b1;
        if (lf_q && !dot_q) cmd.has_break = 1'b1;
        if (dot_q) crdot_d = 1'b1;
      end else if (in_byte_i == CharLf) begin
        if (cr_q) lf_d = 1'b1;
        if (crdot_q) begin
          cmd.has_break = 1'b1;
          cmd.msg_end   = 1'b1;
          ended_d       = 1'b1;
        end
      end else if (in_byte_i == CharDot) begin
        if (dot_q) begin
          cmd.has_break = 1'b1;
          cmd.has_byte  = 1'b1;
          cmd.data      = CharDot;
          cr_d          = 1'b0;
          lf_d          = 1'b0;
          dot_d         = 1'b0;
        end else if (lf_q) begin
          dot_d = 1'b1;
        end else begin
          cmd.has_byte = 1'b1;
          cmd.data     = CharDot;
        end
      end else begin
        if (cr_q && lf_q && (!dot_q || !crdot_q)) cmd.has_break = 1'b1;
        cmd.has_byte = 1'b1;
        cmd.data     = in_byte_i;
        cr_d         = 1'b0;
        lf_d         = 1'b0;
        dot_d        = 1'b0;
        crdot_d      = 1'b0;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.has_break || cmd.has_byte);

  // flag registers, updated per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q    <= 1'b0;
      lf_q    <= 1'b0;
      dot_q   <= 1'b0;
      crdot_q <= 1'b0;
      ended_q <= 1'b0;
    end else if (accept) begin
      cr_q    <= cr_d;
      lf_q    <= lf_d;
      dot_q   <= dot_d;
      crdot_q <= crdot_d;
      ended_q <= ended_d;
    end
  end

  // nothing leaves the classifier once the message has ended
  a_no_push_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q && operation_i == OpData |-> !push_o)
    else $error("command pushed after message end");

endmodule

@@ design/pdu_queue.sv @@
module pdu_queue #(
  parameter int unsigned Depth = pdu_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdu_pkg::cmd_t  cmd_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output pdu_pkg::cmd_t  head_o
);
  import pdu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            full;

  assign full         = (count_q == CntW'(Depth));
  assign ready_o      = !full || pop_i;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue popped while empty");

endmodule

@@ design/pdu_back.sv @@
module pdu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  pdu_pkg::cmd_t  head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output logic           message_end_o
);
  import pdu_pkg::*;

  logic [1:0] phase_q;
  logic       beat_done;
  logic       is_cr, is_lf;

  assign is_cr = head_i.has_break && (phase_q == 2'd0);
  assign is_lf = head_i.has_break && (phase_q == 2'd1);

  // select the byte of the current beat
  always_comb begin
    if (is_cr) begin
      out_byte_o = CharCr;
    end else if (is_lf) begin
      out_byte_o = CharLf;
    end else begin
      out_byte_o = head_i.data;
    end
  end

  assign out_valid_o   = head_valid_i;
  assign last_of_run_o = head_i.has_byte ? (!head_i.has_break || phase_q == 2'd2) : is_lf;
  assign message_end_o = is_lf && head_i.msg_end;
  assign beat_done     = out_valid_o && !out_stall_i;
  assign pop_o         = beat_done && last_of_run_o;

  // beat counter within one command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (beat_done) begin
      phase_q <= last_of_run_o ? 2'd0 : phase_q + 2'd1;
    end
  end

  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd0 |-> head_valid_i)
    else $error("command left queue mid expansion");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> last_of_run_o)
    else $error("message end not on last beat");

  a_phase_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> phase_q == 2'd0)
    else $error("beat counter not cleared after pop");

endmodule
